>>> sv/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants for the MessagePack object skipper.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int LVL_W       = 6;   // level 0..STACK_DEPTH-1
   localparam int IDX_W       = 5;   // stack RAM address
   localparam int CNT_W       = 33;  // pending item count
   localparam int ACC_W       = 32;  // length accumulator
   localparam int IMM_W       = 6;   // immediate count carried by a tag

   localparam logic [LVL_W-1:0] RESET_LIMIT = LVL_W'(32);

   // result status codes
   localparam logic [2:0] ST_MORE       = 3'd0;
   localparam logic [2:0] ST_DONE       = 3'd1;
   localparam logic [2:0] ST_INVALID    = 3'd2;
   localparam logic [2:0] ST_DEPTH      = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;
   localparam logic [2:0] ST_IGNORED    = 3'd5;

   // header kinds
   localparam logic [1:0] HK_BYTES = 2'd0;
   localparam logic [1:0] HK_EXT   = 2'd1;
   localparam logic [1:0] HK_ARRAY = 2'd2;
   localparam logic [1:0] HK_MAP   = 2'd3;

   // tag actions
   localparam logic [2:0] ACT_COMPLETE = 3'd0;
   localparam logic [2:0] ACT_PAYLOAD  = 3'd1;
   localparam logic [2:0] ACT_OPEN     = 3'd2;
   localparam logic [2:0] ACT_HEADER   = 3'd3;
   localparam logic [2:0] ACT_INVALID  = 3'd4;

   typedef struct packed {
      logic [2:0]       act;
      logic [IMM_W-1:0] imm;
      logic [1:0]       hkind;
      logic [2:0]       hbytes;
   } tag_info_type;

endpackage

>>> sv/mps_tag_decode.sv
// ----------------------------------------------------------------------------
// mps_tag_decode
// Classifies one MessagePack tag byte into an action and its immediates.
// ----------------------------------------------------------------------------
module mps_tag_decode (
   input  logic [7:0]            tag_byte,
   output mps_pkg::tag_info_type tag_info
);

   always_comb begin
      tag_info.act    = mps_pkg::ACT_INVALID;
      tag_info.imm    = '0;
      tag_info.hkind  = mps_pkg::HK_BYTES;
      tag_info.hbytes = 3'd0;
      if (tag_byte <= 8'h7f || tag_byte >= 8'he0) begin
         tag_info.act = mps_pkg::ACT_COMPLETE;
      end else if (tag_byte >= 8'ha0 && tag_byte <= 8'hbf) begin
         tag_info.act = mps_pkg::ACT_PAYLOAD;
         tag_info.imm = {1'b0, tag_byte[4:0]};
      end else if (tag_byte >= 8'h90 && tag_byte <= 8'h9f) begin
         tag_info.act = mps_pkg::ACT_OPEN;
         tag_info.imm = {2'b00, tag_byte[3:0]};
      end else if (tag_byte >= 8'h80 && tag_byte <= 8'h8f) begin
         // map: two items per entry
         tag_info.act = mps_pkg::ACT_OPEN;
         tag_info.imm = {1'b0, tag_byte[3:0], 1'b0};
      end else begin
         case (tag_byte)
            8'hc0, 8'hc2, 8'hc3: tag_info.act = mps_pkg::ACT_COMPLETE;
            8'hc4, 8'hd9: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd1;
            end
            8'hc5, 8'hda: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd2;
            end
            8'hc6, 8'hdb: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd4;
            end
            8'hc7: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd1;
               tag_info.hkind = mps_pkg::HK_EXT;
            end
            8'hc8: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd2;
               tag_info.hkind = mps_pkg::HK_EXT;
            end
            8'hc9: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd4;
               tag_info.hkind = mps_pkg::HK_EXT;
            end
            8'hcc, 8'hd0: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd1;
            end
            8'hcd, 8'hd1, 8'hd4: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd2;
            end
            8'hd5: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd3;
            end
            8'hca, 8'hce, 8'hd2: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd4;
            end
            8'hd6: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd5;
            end
            8'hcb, 8'hcf, 8'hd3: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd8;
            end
            8'hd7: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd9;
            end
            8'hd8: begin
               tag_info.act = mps_pkg::ACT_PAYLOAD; tag_info.imm = 6'd17;
            end
            8'hdc: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd2;
               tag_info.hkind = mps_pkg::HK_ARRAY;
            end
            8'hdd: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd4;
               tag_info.hkind = mps_pkg::HK_ARRAY;
            end
            8'hde: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd2;
               tag_info.hkind = mps_pkg::HK_MAP;
            end
            8'hdf: begin
               tag_info.act = mps_pkg::ACT_HEADER; tag_info.hbytes = 3'd4;
               tag_info.hkind = mps_pkg::HK_MAP;
            end
            default: tag_info.act = mps_pkg::ACT_INVALID;
         endcase
      end
   end

endmodule

>>> sv/mps_stack_ram.sv
// ----------------------------------------------------------------------------
// mps_stack_ram
// Pending-count stack for the enclosing levels; one write, one registered read.
// ----------------------------------------------------------------------------
module mps_stack_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [mps_pkg::IDX_W-1:0] wr_addr,
   input  logic [mps_pkg::CNT_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [mps_pkg::IDX_W-1:0] rd_addr,
   output logic [mps_pkg::CNT_W-1:0] rd_data
);

   logic [mps_pkg::CNT_W-1:0] mem [mps_pkg::STACK_DEPTH];
   logic [mps_pkg::CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/msgpack_object_skipper.sv
// ----------------------------------------------------------------------------
// msgpack_object_skipper
// Walks one complete MessagePack object, one byte per transfer, and reports a
// status and the nesting depth for every byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | data_byte, last_byte
//  rsp     | out       | rsp_valid/stall    | status, nesting_depth
//  csr     | in        | csr_valid/ready    | depth_limit (6 bits)
//
//  A byte that closes several containers in cascade reopens each enclosing
//  level from the stack RAM with a registered read, and new bytes are stalled
//  meanwhile. The top-of-stack count lives in a register; the enclosing
//  counts sit in the stack RAM. Reset is synchronous and needs no clearing
//  pass. The result is held in an output register, so a byte is taken while
//  the previous result is being transferred.
// ----------------------------------------------------------------------------
module msgpack_object_skipper (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [mps_pkg::LVL_W-1:0] rsp_nesting_depth,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mps_pkg::LVL_W-1:0] csr_depth_limit
);

   typedef enum logic [1:0] {
      S_RUN = 2'b01,
      S_POP = 2'b10
   } fsm_type;

   typedef enum logic [3:0] {
      PH_TAG      = 4'b0001,
      PH_HEADER   = 4'b0010,
      PH_PAYLOAD  = 4'b0100,
      PH_FINISHED = 4'b1000
   } phase_type;

   fsm_type                   state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [mps_pkg::LVL_W-1:0] limit_ff;
   logic [mps_pkg::LVL_W-1:0] level_ff, level_in;
   logic [mps_pkg::CNT_W-1:0] tos_ff, tos_in;
   logic [mps_pkg::CNT_W-1:0] pay_ff, pay_in;
   logic [mps_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]                hb_ff, hb_in;
   logic [1:0]                hk_ff, hk_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_status_ff, rsp_status_in;
   logic [mps_pkg::LVL_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic                      take;
   logic [mps_pkg::LVL_W-1:0] eff_limit;
   mps_pkg::tag_info_type     tag_info;

   logic                      wr_en, rd_en;
   logic [mps_pkg::IDX_W-1:0] wr_addr, rd_addr;
   logic [mps_pkg::CNT_W-1:0] rd_data;

   mps_tag_decode u_dec (
      .tag_byte (req_data_byte),
      .tag_info (tag_info)
   );

   mps_stack_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tos_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_RUN) || (rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall;
   assign eff_limit = (limit_ff > mps_pkg::LVL_W'(mps_pkg::STACK_DEPTH)) ?
                      mps_pkg::LVL_W'(mps_pkg::STACK_DEPTH) : limit_ff;

   always_comb begin
      logic                      cmp;
      logic [mps_pkg::CNT_W-1:0] cmp_cnt;
      logic [mps_pkg::CNT_W-1:0] dec;
      logic [mps_pkg::CNT_W-1:0] opn;   // count of a container to open
      logic                      do_open;
      logic [mps_pkg::CNT_W-1:0] pl;    // payload length to start
      logic                      do_pay;
      logic [mps_pkg::ACC_W-1:0] acc_nx;
      logic [2:0]                hb_nx;
      logic [mps_pkg::LVL_W-1:0] lvl_dn;
      logic                      fin;
      logic                      lst;
      logic [2:0]                st;

      state_in = state_ff;  phase_in = phase_ff;  level_in = level_ff;
      tos_in = tos_ff;      pay_in = pay_ff;      acc_in = acc_ff;
      hb_in = hb_ff;        hk_in = hk_ff;        last_in = last_ff;
      wr_en = 1'b0;         rd_en = 1'b0;
      wr_addr = level_ff[mps_pkg::IDX_W-1:0] - 1'b1;
      rd_addr = '0;
      cmp = 1'b0;           cmp_cnt = tos_ff;     dec = '0;
      opn = '0;             do_open = 1'b0;
      pl = '0;              do_pay = 1'b0;
      acc_nx = '0;          hb_nx = '0;           lvl_dn = '0;
      fin = 1'b0;           st = mps_pkg::ST_MORE;
      lst = last_ff;

      if (state_ff == S_RUN && take) begin
         lst     = req_last_byte;
         last_in = req_last_byte;
         case (phase_ff)
            PH_TAG: begin
               if (level_ff >= eff_limit) begin
                  st = mps_pkg::ST_DEPTH; fin = 1'b1;
               end else begin
                  case (tag_info.act)
                     mps_pkg::ACT_COMPLETE: cmp = 1'b1;
                     mps_pkg::ACT_PAYLOAD: begin
                        do_pay = 1'b1;
                        pl = mps_pkg::CNT_W'(tag_info.imm);
                     end
                     mps_pkg::ACT_OPEN: begin
                        do_open = 1'b1;
                        opn = mps_pkg::CNT_W'(tag_info.imm);
                     end
                     mps_pkg::ACT_HEADER: begin
                        hk_in = tag_info.hkind;
                        hb_in = tag_info.hbytes;
                        acc_in = '0;
                        phase_in = PH_HEADER;
                        fin = 1'b1;
                     end
                     default: begin
                        st = mps_pkg::ST_INVALID; fin = 1'b1;
                     end
                  endcase
               end
            end
            PH_HEADER: begin
               acc_nx = {acc_ff[mps_pkg::ACC_W-9:0], req_data_byte};
               hb_nx  = hb_ff - 1'b1;
               acc_in = acc_nx;
               hb_in  = hb_nx;
               if (hb_nx != 3'd0) begin
                  fin = 1'b1;
               end else begin
                  case (hk_ff)
                     mps_pkg::HK_BYTES: begin
                        do_pay = 1'b1; pl = {1'b0, acc_nx};
                     end
                     mps_pkg::HK_EXT: begin
                        do_pay = 1'b1; pl = {1'b0, acc_nx} + 1'b1;
                     end
                     mps_pkg::HK_ARRAY: begin
                        do_open = 1'b1; opn = {1'b0, acc_nx};
                     end
                     default: begin
                        do_open = 1'b1; opn = {acc_nx, 1'b0};
                     end
                  endcase
               end
            end
            PH_PAYLOAD: begin
               dec = (pay_ff != '0) ? pay_ff - 1'b1 : pay_ff;
               pay_in = dec;
               if (dec == '0) begin
                  cmp = 1'b1;
               end else begin
                  fin = 1'b1;
               end
            end
            default: begin
               st = mps_pkg::ST_IGNORED; fin = 1'b1;
            end
         endcase

         if (do_pay) begin
            if (pl == '0) begin
               cmp = 1'b1;
            end else begin
               pay_in = pl; phase_in = PH_PAYLOAD; fin = 1'b1;
            end
         end
         if (do_open) begin
            if (opn == '0) begin
               cmp = 1'b1;
            end else if (level_ff + 1'b1 >= eff_limit) begin
               st = mps_pkg::ST_DEPTH; fin = 1'b1;
            end else begin
               // spill the current top count, then push
               wr_en = (level_ff != '0);
               tos_in = opn;
               level_in = level_ff + 1'b1;
               phase_in = PH_TAG;
               fin = 1'b1;
            end
         end
      end else if (state_ff == S_POP) begin
         cmp = 1'b1;
         cmp_cnt = rd_data;
      end

      // one item finished at the current level; close containers in cascade
      if (cmp) begin
         phase_in = PH_TAG;
         if (level_ff == '0) begin
            st = mps_pkg::ST_DONE; fin = 1'b1; state_in = S_RUN;
         end else begin
            dec = cmp_cnt - 1'b1;
            if (dec != '0) begin
               tos_in = dec; fin = 1'b1; state_in = S_RUN;
            end else begin
               lvl_dn = level_ff - 1'b1;
               level_in = lvl_dn;
               if (lvl_dn == '0) begin
                  st = mps_pkg::ST_DONE; fin = 1'b1; state_in = S_RUN;
               end else begin
                  // reopen the enclosing level from the stack
                  rd_en = 1'b1;
                  rd_addr = lvl_dn[mps_pkg::IDX_W-1:0] - 1'b1;
                  state_in = S_POP;
               end
            end
         end
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      if (fin) begin
         if (st != mps_pkg::ST_MORE) begin
            phase_in = PH_FINISHED;
         end else if (lst) begin
            st = mps_pkg::ST_INCOMPLETE;
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = st;
         rsp_depth_in  = level_in;
         // rearm for a new object after the final byte
         if (lst) begin
            level_in = '0; pay_in = '0; acc_in = '0;
            hb_in = '0;    hk_in = '0;  phase_in = PH_TAG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         phase_ff     <= PH_TAG;
         limit_ff     <= mps_pkg::RESET_LIMIT;
         level_ff     <= '0;
         pay_ff       <= '0;
         acc_ff       <= '0;
         hb_ff        <= '0;
         hk_ff        <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         pay_ff       <= pay_in;
         acc_ff       <= acc_in;
         hb_ff        <= hb_in;
         hk_ff        <= hk_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_depth_limit;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_nesting_depth = rsp_depth_ff;

endmodule
